### design/ardr_pkg.sv
// shared types, constants and helpers for the art-net dmx packet router
`default_nettype none

package ardr_pkg;

   localparam int PACKET_CAPACITY = 550;
   localparam int UNIVERSE_SLOTS  = 512;
   localparam int QUEUE_DEPTH     = 4;

   localparam int POS_W  = 10;
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 7;

   localparam logic [POS_W-1:0] POS_MAX    = 10'd1023;
   localparam logic [POS_W-1:0] DATA_START = 10'd18;

   localparam logic [15:0] OP_DMX       = 16'h5000;
   localparam logic [15:0] OP_POLL      = 16'h2000;
   localparam logic [15:0] OP_POLLREPLY = 16'h2100;

   localparam logic [6:0] NODE_NET_RESET    = 7'd0;
   localparam logic [3:0] NODE_SUBNET_RESET = 4'd0;
   localparam logic [3:0] UNIVERSE_A_RESET  = 4'd1;
   localparam logic [3:0] UNIVERSE_B_RESET  = 4'd2;
   localparam logic [3:0] UNIVERSE_C_RESET  = 4'd3;
   localparam logic [3:0] UNIVERSE_D_RESET  = 4'd4;

   typedef enum logic [CSR_IW-1:0] {
      CSR_NODE_NET,
      CSR_NODE_SUBNET,
      CSR_UNIVERSE_A,
      CSR_UNIVERSE_B,
      CSR_UNIVERSE_C,
      CSR_UNIVERSE_D
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_NOT_ARTNET,
      ST_DMX_ROUTED,
      ST_DMX_NOT_OURS,
      ST_POLL,
      ST_POLLREPLY,
      ST_UNKNOWN,
      ST_TRUNCATED
   } status_type;

   typedef struct packed {
      logic       write_valid;
      logic [3:0] output_mask;
      logic [8:0] channel;
      logic [7:0] slot_value;
      logic       packet_end;
      status_type packet_status;
   } result_type;

   // art-net id string with trailing nul
   function automatic logic [7:0] id_byte(input logic [2:0] pos);
      logic [7:0] b;
      unique case (pos)
         3'd0: b = 8'h41;
         3'd1: b = 8'h72;
         3'd2: b = 8'h74;
         3'd3: b = 8'h2D;
         3'd4: b = 8'h4E;
         3'd5: b = 8'h65;
         3'd6: b = 8'h74;
         3'd7: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

### design/ardr_parser.sv
// front end: header parsing, routing match and per-byte classification
`default_nettype none

module ardr_parser #(
   parameter int PACKET_CAPACITY = ardr_pkg::PACKET_CAPACITY,
   parameter int UNIVERSE_SLOTS  = ardr_pkg::UNIVERSE_SLOTS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [7:0]                  rx_byte,
   input  wire logic                        rx_last,
   input  wire logic                        csr_write_enable,
   input  wire logic [ardr_pkg::CSR_IW-1:0] csr_index,
   input  wire logic [ardr_pkg::CSR_DW-1:0] csr_write_data,
   output logic                             push,
   output ardr_pkg::result_type             result
);

   localparam int NEED_LIMIT = (UNIVERSE_SLOTS < PACKET_CAPACITY - 18) ?
                               UNIVERSE_SLOTS : PACKET_CAPACITY - 18;
   localparam logic [ardr_pkg::POS_W-1:0] SLOTS_L = ardr_pkg::POS_W'(UNIVERSE_SLOTS);
   localparam logic [ardr_pkg::POS_W-1:0] CAP_L   = ardr_pkg::POS_W'(PACKET_CAPACITY);
   localparam logic [15:0]                NEED_L  = 16'(NEED_LIMIT);
   localparam logic [ardr_pkg::POS_W-1:0] POS_OPLO  = 10'd8;
   localparam logic [ardr_pkg::POS_W-1:0] POS_OPHI  = 10'd9;
   localparam logic [ardr_pkg::POS_W-1:0] POS_SUB   = 10'd14;
   localparam logic [ardr_pkg::POS_W-1:0] POS_NET   = 10'd15;
   localparam logic [ardr_pkg::POS_W-1:0] POS_LENHI = 10'd16;
   localparam logic [ardr_pkg::POS_W-1:0] POS_LENLO = 10'd17;

   logic [6:0] node_net_ff;
   logic [3:0] node_subnet_ff;
   logic [3:0] universe_a_ff, universe_b_ff, universe_c_ff, universe_d_ff;

   logic [ardr_pkg::POS_W-1:0] pos_ff, pos_in;
   logic        header_ff, header_in;
   logic [15:0] opcode_ff, opcode_in;
   logic        net_ff, net_in;
   logic [15:0] len_ff, len_in;
   logic [3:0]  route_ff, route_in;

   logic                       ours;
   logic [ardr_pkg::POS_W-1:0] idx;
   logic [ardr_pkg::POS_W-1:0] got;
   logic [15:0]                need;
   logic                       wr;
   ardr_pkg::status_type       status;

   always_comb begin
      header_in = header_ff;
      opcode_in = opcode_ff;
      net_in    = net_ff;
      len_in    = len_ff;
      route_in  = route_ff;
      if (pos_ff < POS_OPLO) begin
         if (rx_byte != ardr_pkg::id_byte(pos_ff[2:0])) begin
            header_in = 1'b0;
         end
      end
      if (pos_ff == POS_OPLO) begin
         opcode_in[7:0] = rx_byte;
      end
      if (pos_ff == POS_OPHI) begin
         opcode_in[15:8] = rx_byte;
      end
      if (pos_ff == POS_SUB) begin
         route_in[0] = (rx_byte == {node_subnet_ff, universe_a_ff});
         route_in[1] = (rx_byte == {node_subnet_ff, universe_b_ff});
         route_in[2] = (rx_byte == {node_subnet_ff, universe_c_ff});
         route_in[3] = (rx_byte == {node_subnet_ff, universe_d_ff});
      end
      if (pos_ff == POS_NET) begin
         net_in = (rx_byte == {1'b0, node_net_ff});
      end
      if (pos_ff == POS_LENHI) begin
         len_in[15:8] = rx_byte;
      end
      if (pos_ff == POS_LENLO) begin
         len_in[7:0] = rx_byte;
      end
   end

   always_comb begin
      ours = header_in && (opcode_in == ardr_pkg::OP_DMX) && net_in && (route_in != 4'd0);
      idx  = pos_ff - ardr_pkg::DATA_START;
      got  = pos_ff - POS_LENLO;
      need = (len_in < NEED_L) ? len_in : NEED_L;
      wr   = (pos_ff >= ardr_pkg::DATA_START) && ours && ({6'd0, idx} < len_in) &&
             (idx < SLOTS_L) && (pos_ff < CAP_L);
   end

   always_comb begin
      priority if (!header_in) begin
         status = ardr_pkg::ST_NOT_ARTNET;
      end else if (pos_ff < POS_OPHI) begin
         status = ardr_pkg::ST_TRUNCATED;
      end else if (opcode_in == ardr_pkg::OP_DMX) begin
         priority if (pos_ff < POS_LENLO) begin
            status = ardr_pkg::ST_TRUNCATED;
         end else if (!ours) begin
            status = ardr_pkg::ST_DMX_NOT_OURS;
         end else if ({6'd0, got} < need) begin
            status = ardr_pkg::ST_TRUNCATED;
         end else begin
            status = ardr_pkg::ST_DMX_ROUTED;
         end
      end else if (opcode_in == ardr_pkg::OP_POLL) begin
         status = ardr_pkg::ST_POLL;
      end else if (opcode_in == ardr_pkg::OP_POLLREPLY) begin
         status = ardr_pkg::ST_POLLREPLY;
      end else begin
         status = ardr_pkg::ST_UNKNOWN;
      end
   end

   always_comb begin
      push                 = accept && (wr || rx_last);
      result.write_valid   = wr;
      result.output_mask   = wr ? route_in : 4'd0;
      result.channel       = wr ? idx[8:0] : 9'd0;
      result.slot_value    = wr ? rx_byte : 8'd0;
      result.packet_end    = rx_last;
      result.packet_status = rx_last ? status : ardr_pkg::ST_NOT_ARTNET;
      pos_in = pos_ff;
      if (rx_last) begin
         pos_in = '0;
      end else if (pos_ff < ardr_pkg::POS_MAX) begin
         pos_in = pos_ff + 10'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         header_ff <= 1'b1;
         opcode_ff <= '0;
         net_ff    <= 1'b0;
         len_ff    <= '0;
         route_ff  <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         if (rx_last) begin
            header_ff <= 1'b1;
            opcode_ff <= '0;
            net_ff    <= 1'b0;
            len_ff    <= '0;
            route_ff  <= '0;
         end else begin
            header_ff <= header_in;
            opcode_ff <= opcode_in;
            net_ff    <= net_in;
            len_ff    <= len_in;
            route_ff  <= route_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_net_ff    <= ardr_pkg::NODE_NET_RESET;
         node_subnet_ff <= ardr_pkg::NODE_SUBNET_RESET;
         universe_a_ff  <= ardr_pkg::UNIVERSE_A_RESET;
         universe_b_ff  <= ardr_pkg::UNIVERSE_B_RESET;
         universe_c_ff  <= ardr_pkg::UNIVERSE_C_RESET;
         universe_d_ff  <= ardr_pkg::UNIVERSE_D_RESET;
      end else if (csr_write_enable) begin
         unique case (ardr_pkg::csr_index_type'(csr_index))
            ardr_pkg::CSR_NODE_NET:    node_net_ff    <= csr_write_data;
            ardr_pkg::CSR_NODE_SUBNET: node_subnet_ff <= csr_write_data[3:0];
            ardr_pkg::CSR_UNIVERSE_A:  universe_a_ff  <= csr_write_data[3:0];
            ardr_pkg::CSR_UNIVERSE_B:  universe_b_ff  <= csr_write_data[3:0];
            ardr_pkg::CSR_UNIVERSE_C:  universe_c_ff  <= csr_write_data[3:0];
            ardr_pkg::CSR_UNIVERSE_D:  universe_d_ff  <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_last_clears_pos: assert property (@(posedge clock) disable iff (reset)
      accept && rx_last |=> pos_ff == '0)
      else $error("position not cleared after last item");
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      push |-> accept)
      else $error("push without accepted item");
   a_write_in_data: assert property (@(posedge clock) disable iff (reset)
      push && result.write_valid |-> pos_ff >= ardr_pkg::DATA_START && pos_ff < CAP_L)
      else $error("write outside data region");
`endif

endmodule

`default_nettype wire

### design/ardr_queue.sv
// back end: short result queue whose head drives the response channel
`default_nettype none

module ardr_queue #(
   parameter int DEPTH = ardr_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire ardr_pkg::result_type push_data,
   output logic                      full,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output ardr_pkg::result_type      head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ardr_pkg::result_type entries_ff [DEPTH];
   ardr_pkg::result_type entries_in [DEPTH];
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     wr_cnt;
   logic                 pop;

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      rsp_valid = (count_ff != '0);
      head      = entries_ff[0];
      pop       = rsp_valid && rsp_ready;
      wr_cnt    = pop ? count_ff - CNT_W'(1) : count_ff;
      count_in  = wr_cnt + CNT_W'(push);
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            entries_in[i] = entries_ff[i+1];
         end
      end
      if (push) begin
         entries_in[wr_cnt[PTR_W-1:0]] = push_data;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not drain queue");
`endif

endmodule

`default_nettype wire

### design/artnet_dmx_packet_router.sv
// top level of the art-net dmx packet router
//
// req channel: one udp payload byte per item (req_rx_byte), req_rx_last on the
// final byte of each packet. any byte may be offered in any cycle.
// rsp channel: one item per dmx slot write that routes to at least one output,
// and one item on the last byte of every packet, its slot write if it has one,
// carrying packet_end and status; bytes that are neither produce nothing.
// csr port: write-only, csr_index selects node_net, node_subnet, universe_a..d.
// throughput: one byte per cycle while req_ready is high, set by the header parser.
// each result enters the queue when its byte is accepted, behind any results not yet taken.
// a four-item queue sits between parser and rsp; when rsp_ready is held low the
// queue fills and req_ready drops once it holds four items, resuming the cycle
// after a result is taken.
// reset: parse state returns to the start of a packet, the queue empties,
// node_net and node_subnet clear and universes a..d return to 1..4.
`default_nettype none

module artnet_dmx_packet_router #(
   parameter int PACKET_CAPACITY = ardr_pkg::PACKET_CAPACITY,
   parameter int UNIVERSE_SLOTS  = ardr_pkg::UNIVERSE_SLOTS,
   parameter int QUEUE_DEPTH     = ardr_pkg::QUEUE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_rx_byte,
   input  wire logic                        req_rx_last,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_write_valid,
   output logic [3:0]                       rsp_output_mask,
   output logic [8:0]                       rsp_channel,
   output logic [7:0]                       rsp_slot_value,
   output logic                             rsp_packet_end,
   output logic [2:0]                       rsp_packet_status,
   input  wire logic                        csr_write_enable,
   input  wire logic [ardr_pkg::CSR_IW-1:0] csr_index,
   input  wire logic [ardr_pkg::CSR_DW-1:0] csr_write_data
);

   logic                 accept;
   logic                 push;
   logic                 full;
   ardr_pkg::result_type result;
   ardr_pkg::result_type head;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   ardr_parser #(
      .PACKET_CAPACITY(PACKET_CAPACITY),
      .UNIVERSE_SLOTS (UNIVERSE_SLOTS)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .rx_byte         (req_rx_byte),
      .rx_last         (req_rx_last),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .push            (push),
      .result          (result)
   );

   ardr_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(result),
      .full     (full),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .head     (head)
   );

   assign rsp_write_valid   = head.write_valid;
   assign rsp_output_mask   = head.output_mask;
   assign rsp_channel       = head.channel;
   assign rsp_slot_value    = head.slot_value;
   assign rsp_packet_end    = head.packet_end;
   assign rsp_packet_status = head.packet_status;

endmodule

`default_nettype wire

### tb/artdmx_check_pkg.sv
// scoreboard that predicts and checks the router's slot writes and packet status
`timescale 1ns / 100ps

package artdmx_check_pkg;
   import ardr_pkg::*;

   localparam logic [63:0] ARTNET_ID   = {"Art-Net", 8'h00};
   localparam logic [9:0]  ID_LEN      = 10'd8;
   localparam logic [9:0]  POS_OP_LO   = 10'd8;
   localparam logic [9:0]  POS_OP_HI   = 10'd9;
   localparam logic [9:0]  POS_SUBUNI  = 10'd14;
   localparam logic [9:0]  POS_NET     = 10'd15;
   localparam logic [9:0]  POS_LEN_HI  = 10'd16;
   localparam logic [9:0]  POS_LEN_LO  = 10'd17;

   class artdmx_scoreboard;
      logic [6:0]  node_net;
      logic [3:0]  node_subnet;
      logic [3:0]  universe [4];
      logic [9:0]  pos;
      bit          id_ok;
      logic [15:0] opcode;
      logic [7:0]  subuni;
      bit          net_ok;
      logic [15:0] dmx_len;
      logic [3:0]  route;
      result_type  results_due [$];
      int          failures;

      function new();
         failures    = 0;
         node_net    = NODE_NET_RESET;
         node_subnet = NODE_SUBNET_RESET;
         universe[0] = UNIVERSE_A_RESET;
         universe[1] = UNIVERSE_B_RESET;
         universe[2] = UNIVERSE_C_RESET;
         universe[3] = UNIVERSE_D_RESET;
         clear_packet();
      endfunction

      function void clear_packet();
         pos     = '0;
         id_ok   = 1'b1;
         opcode  = '0;
         subuni  = '0;
         net_ok  = 1'b0;
         dmx_len = '0;
         route   = '0;
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      function void note_config(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] value);
         case (idx)
            CSR_NODE_NET:    node_net    = value;
            CSR_NODE_SUBNET: node_subnet = value[3:0];
            CSR_UNIVERSE_A:  universe[0] = value[3:0];
            CSR_UNIVERSE_B:  universe[1] = value[3:0];
            CSR_UNIVERSE_C:  universe[2] = value[3:0];
            CSR_UNIVERSE_D:  universe[3] = value[3:0];
            default: ;
         endcase
      endfunction

      // one accepted item: advance the parse and queue any result it causes
      function void take_byte(logic [7:0] b, logic last);
         logic [9:0] p;
         result_type r;
         bit ours;
         int idx;
         int need;
         int got_n;
         p = pos;
         r = '0;
         if (p < ID_LEN) begin
            if (b != ARTNET_ID[8*(7-int'(p)) +: 8]) id_ok = 1'b0;
         end else if (p == POS_OP_LO) begin
            opcode[7:0] = b;
         end else if (p == POS_OP_HI) begin
            opcode[15:8] = b;
         end else if (p == POS_SUBUNI) begin
            subuni = b;
            route = '0;
            for (int i = 0; i < 4; i++)
               if (b == {node_subnet, universe[i]}) route[i] = 1'b1;
         end else if (p == POS_NET) begin
            net_ok = (b == {1'b0, node_net});
         end else if (p == POS_LEN_HI) begin
            dmx_len[15:8] = b;
         end else if (p == POS_LEN_LO) begin
            dmx_len[7:0] = b;
         end

         ours = id_ok && opcode == OP_DMX && net_ok && route != '0;
         idx = int'(p) - int'(DATA_START);
         if (p >= DATA_START && ours && idx < int'(dmx_len) && idx < UNIVERSE_SLOTS &&
             int'(p) < PACKET_CAPACITY) begin
            r.write_valid = 1'b1;
            r.output_mask = route;
            r.channel     = idx[8:0];
            r.slot_value  = b;
         end

         if (last) begin
            r.packet_end = 1'b1;
            if (!id_ok) begin
               r.packet_status = ST_NOT_ARTNET;
            end else if (p < POS_OP_HI) begin
               r.packet_status = ST_TRUNCATED;
            end else if (opcode == OP_DMX) begin
               if (p < POS_LEN_LO) begin
                  r.packet_status = ST_TRUNCATED;
               end else if (!ours) begin
                  r.packet_status = ST_DMX_NOT_OURS;
               end else begin
                  need = int'(dmx_len);
                  if (need > UNIVERSE_SLOTS) need = UNIVERSE_SLOTS;
                  if (need > PACKET_CAPACITY - int'(DATA_START))
                     need = PACKET_CAPACITY - int'(DATA_START);
                  got_n = int'(p) + 1 - int'(DATA_START);
                  r.packet_status = (got_n < need) ? ST_TRUNCATED : ST_DMX_ROUTED;
               end
            end else if (opcode == OP_POLL) begin
               r.packet_status = ST_POLL;
            end else if (opcode == OP_POLLREPLY) begin
               r.packet_status = ST_POLLREPLY;
            end else begin
               r.packet_status = ST_UNKNOWN;
            end
            clear_packet();
         end else if (pos < POS_MAX) begin
            pos = pos + 10'd1;
         end

         if (r.write_valid || last) results_due.push_back(r);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
         if (seen !== want) begin
            failures++;
            $error("%s: expected %0d, got %0d", name, want, seen);
         end
      endfunction

      function void check_result(result_type seen);
         result_type want;
         if (results_due.size() == 0) begin
            failures++;
            $error("result with nothing expected: write_valid %0d channel %0d end %0d",
                   seen.write_valid, seen.channel, seen.packet_end);
            return;
         end
         want = results_due.pop_front();
         compare_field("write_valid", want.write_valid, seen.write_valid);
         compare_field("output_mask", want.output_mask, seen.output_mask);
         compare_field("channel", want.channel, seen.channel);
         compare_field("slot_value", want.slot_value, seen.slot_value);
         compare_field("packet_end", want.packet_end, seen.packet_end);
         compare_field("packet_status", want.packet_status, seen.packet_status);
      endfunction
   endclass

endpackage

### tb/tb_artnet_dmx_packet_router.sv
// testbench for the art-net dmx packet router: directed and random packets, checked per item
`timescale 1ns / 100ps

module tb_artnet_dmx_packet_router;
   import ardr_pkg::*;
   import artdmx_check_pkg::*;

   localparam int RESET_CYCLES = 10;
   localparam int QUIET_CYCLES = 8;
   localparam int ITEM_TARGET  = 450;
   localparam int CYCLE_LIMIT  = 600000;
   localparam logic [CSR_IW-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [15:0] OP_UNLISTED = 16'h8000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = '0;
   logic req_rx_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_write_valid;
   logic [3:0] rsp_output_mask;
   logic [8:0] rsp_channel;
   logic [7:0] rsp_slot_value;
   logic rsp_packet_end;
   logic [2:0] rsp_packet_status;
   logic csr_write_enable = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_write_data = '0;

   artdmx_scoreboard sb;
   result_type rsp_seen;
   logic [7:0] frame [$];
   int burst_left = 0;
   int idle_gap = 0;
   int items_sent = 0;
   int stall_phase = 0;
   int stall_mode = 0;
   int cycle_count = 0;

   artnet_dmx_packet_router dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .req_rx_last       (req_rx_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_output_mask   (rsp_output_mask),
      .rsp_channel       (rsp_channel),
      .rsp_slot_value    (rsp_slot_value),
      .rsp_packet_end    (rsp_packet_end),
      .rsp_packet_status (rsp_packet_status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #2 clock = ~clock;

   assign rsp_seen = {rsp_write_valid, rsp_output_mask, rsp_channel, rsp_slot_value,
                      rsp_packet_end, rsp_packet_status};

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_seen);
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_phase = $urandom_range(8, 80);
      end
      stall_phase--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom);
         2: rsp_ready <= ($urandom_range(0, 7) != 0);
         default: rsp_ready <= ((stall_phase % 16) < 3);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         idle_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (idle_gap != 0) begin
            req_valid <= 1'b0;
            repeat (idle_gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_rx_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_byte(b, last);
      burst_left--;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
      items_sent += frame.size();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      sb.note_config(idx, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // nibble registers ignore the upper data bits
   function automatic logic [CSR_DW-1:0] with_junk(input logic [3:0] v);
      logic [2:0] junk;
      junk = 3'($urandom);
      return {junk, v};
   endfunction

   function automatic void put_header(input logic [15:0] op);
      frame.delete();
      for (int i = 0; i < 8; i++) frame.push_back(ARTNET_ID[8*(7-i) +: 8]);
      frame.push_back(op[7:0]);
      frame.push_back(op[15:8]);
   endfunction

   function automatic void pad_frame(input int n);
      repeat (n) frame.push_back(8'($urandom));
   endfunction

   function automatic void put_dmx(input logic [7:0] subuni, input logic [7:0] net,
                                   input logic [15:0] len, input int count);
      put_header(OP_DMX);
      pad_frame(4);
      frame.push_back(subuni);
      frame.push_back(net);
      frame.push_back(len[15:8]);
      frame.push_back(len[7:0]);
      pad_frame(count);
   endfunction

   function automatic void cut_frame(input int n);
      while (frame.size() > n) void'(frame.pop_back());
   endfunction

   task automatic shuffle_config();
      csr_index_type r;
      logic [CSR_DW-1:0] v;
      drain();
      r = r.first();
      do begin
         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 3))
               0: v = '0;
               1: v = '1;
               default: v = 7'($urandom);
            endcase
            if (r != CSR_NODE_NET) v[6:4] = 3'($urandom);
            write_reg(r, v);
         end
         r = r.next();
      end while (r != r.first());
   endtask

   task automatic random_frame();
      int pick;
      int roll;
      int len;
      int base;
      int count;
      logic [7:0] subuni;
      logic [7:0] net;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         subuni = ($urandom_range(0, 3) != 0) ?
                  {sb.node_subnet, sb.universe[$urandom_range(0, 3)]} : 8'($urandom);
         net = ($urandom_range(0, 4) != 0) ? {1'b0, sb.node_net} : 8'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 70) len = $urandom_range(0, 24);
         else if (roll < 90) len = $urandom_range(25, 64);
         else len = $urandom_range(0, 65535);
         base = (len > 48) ? $urandom_range(0, 48) : len;
         roll = $urandom_range(0, 9);
         if (roll < 6) count = base;
         else if (roll < 8) count = base + $urandom_range(1, 4);
         else count = $urandom_range(0, base);
         put_dmx(subuni, net, 16'(len), count);
         if ($urandom_range(0, 19) == 0) cut_frame($urandom_range(10, 17));
      end else if (pick < 65) begin
         put_header(($urandom_range(0, 1) != 0) ? OP_POLL : OP_POLLREPLY);
         pad_frame($urandom_range(0, 10));
      end else if (pick < 72) begin
         put_header(16'($urandom));
         pad_frame($urandom_range(0, 10));
      end else if (pick < 82) begin
         put_dmx({sb.node_subnet, sb.universe[0]}, {1'b0, sb.node_net}, 16'd4, 4);
         frame[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
      end else if (pick < 90) begin
         put_header(OP_DMX);
         cut_frame($urandom_range(1, 9));
      end else begin
         frame.delete();
         pad_frame($urandom_range(1, 30));
      end
      send_frame();
   endtask

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config: net 0, subnet 0, universes 1..4
      put_dmx(8'h01, 8'h00, 16'd4, 4);   send_frame();
      put_dmx(8'h04, 8'h00, 16'd3, 3);   send_frame();
      put_dmx(8'h02, 8'h00, 16'd10, 3);  send_frame();
      put_dmx(8'h01, 8'h00, 16'd0, 0);   send_frame();
      put_dmx(8'h01, 8'h80, 16'd4, 4);   send_frame();
      put_dmx(8'h05, 8'h00, 16'd4, 4);   send_frame();
      put_dmx(8'h11, 8'h00, 16'd4, 4);   send_frame();
      put_dmx(8'h01, 8'h00, 16'd4, 0);   cut_frame(16); send_frame();
      put_header(OP_POLL);               pad_frame(4);  send_frame();
      put_header(OP_POLLREPLY);          send_frame();
      put_header(OP_UNLISTED);           pad_frame(2);  send_frame();
      put_dmx(8'h01, 8'h00, 16'd4, 4);   frame[3] ^= 8'h20; send_frame();
      put_dmx(8'h01, 8'h00, 16'd4, 4);   frame[7] = 8'hFF;  send_frame();
      put_header(OP_DMX);                cut_frame(5);  send_frame();
      put_header(OP_DMX);                cut_frame(9);  send_frame();
      put_header(OP_DMX);                cut_frame(1);  send_frame();
      frame.delete();                    frame.push_back(8'h00); send_frame();

      drain();
      write_reg(CSR_NODE_NET, 7'h7F);
      write_reg(CSR_NODE_SUBNET, with_junk(4'hF));
      write_reg(CSR_UNIVERSE_A, with_junk(4'hF));
      write_reg(CSR_UNIVERSE_B, with_junk(4'hF));
      write_reg(CSR_UNIVERSE_C, with_junk(4'h0));
      write_reg(CSR_UNIVERSE_D, with_junk(4'h9));
      put_dmx(8'hFF, 8'h7F, 16'd4, 4);     send_frame();
      put_dmx(8'hF0, 8'h7F, 16'd3, 3);     send_frame();
      put_dmx(8'hFF, 8'hFF, 16'd4, 4);     send_frame();
      put_dmx(8'hF9, 8'h7F, 16'd600, 6);   send_frame();

      drain();
      write_reg(CSR_SPARE_LO, 7'h55);
      write_reg(CSR_SPARE_HI, 7'h2A);
      write_reg(CSR_NODE_NET, 7'h00);
      write_reg(CSR_NODE_SUBNET, with_junk(4'h0));
      write_reg(CSR_UNIVERSE_A, with_junk(4'h0));
      write_reg(CSR_UNIVERSE_B, with_junk(4'h0));
      write_reg(CSR_UNIVERSE_C, with_junk(4'h0));
      write_reg(CSR_UNIVERSE_D, with_junk(4'h0));
      put_dmx(8'h00, 8'h00, 16'd6, 6);     send_frame();

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 7) == 0) shuffle_config();
         random_frame();
      end

      drain();
      if (sb.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
